>>> design/sbcc_pkg.sv
// shared types and constants for the segment box collision checker
// no dependencies; imported by every other design file
`default_nettype none

package sbcc_pkg;

  localparam int COORD_BITS        = 24;
  localparam int MAX_DIMS          = 3;
  localparam int DEF_MAX_OBSTACLES = 64;
  localparam int SIZE_W            = 23;
  localparam int STEP_W            = 23;
  localparam int CFG_W             = 23;
  localparam int CFG_IDX_W         = 3;
  localparam int CMD_W             = 2;
  localparam int SLOT_W            = 6;
  localparam int DIM_W             = 2;
  localparam int EXTRA_FRAC        = 16;
  localparam int OUT_LEN_W         = 25;

  localparam int AD_W        = COORD_BITS + 1;
  localparam int PROD_W      = 2 * AD_W;
  localparam int SUM_W       = PROD_W + 2;
  localparam int SQRT_STEPS  = SUM_W / 2;
  localparam int LEN_W       = SUM_W / 2;
  localparam int DVD_W       = AD_W + STEP_W + EXTRA_FRAC;
  localparam int MAG_W       = STEP_W + EXTRA_FRAC + 1;
  localparam int DVS_W       = MAG_W + 1;
  localparam int BND_W       = COORD_BITS + EXTRA_FRAC + 4;
  localparam int K_W         = BND_W + 2;

  typedef enum logic [CMD_W-1:0] {
    CMD_CLEAR = 2'd0,
    CMD_LOAD  = 2'd1,
    CMD_CHECK = 2'd2
  } cmd_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DIMS    = 3'd0,
    REG_ROBOT_X = 3'd1,
    REG_ROBOT_Y = 3'd2,
    REG_ROBOT_Z = 3'd3,
    REG_STEP    = 3'd4
  } reg_t;

  typedef struct packed {
    logic             accept;
    logic             clear;
    logic             load;
    logic             sq_mul;
    logic             sq_acc;
    logic             sqrt_init;
    logic             sqrt_step;
    logic             ndiv_start;
    logic             n_store;
    logic             imul;
    logic             idiv_start;
    logic             mag_store;
    logic             mem_rd;
    logic             walk_init;
    logic             walk_prep;
    logic             lo_start;
    logic             lo_store;
    logic             hi_start;
    logic             hi_store;
    logic             finish;
    logic             hit;
    logic [DIM_W-1:0] dim;
  } sbcc_ctl_t;

  typedef struct packed {
    logic [DIM_W-1:0] dims;
    logic             len_zero;
    logic             n_zero;
    logic             div_done;
    logic             obs_valid;
    logic             m_zero;
    logic             outside;
    logic             lo_gt_hi;
    logic             point_hit;
  } sbcc_sts_t;

endpackage

`default_nettype wire

>>> design/segment_box_collision_check_top.sv
// check words: squares and a root for the length, a divide for the step count (none when
// the length is zero), a multiply and a divide per axis for the walk increment, a scan of
// the table, two divides per walked axis per valid box, the result; sequential, no overlap
// clear and load words act at the accept edge, produce no result and leave busy low
// one-cycle done strobe, receiver cannot stall; sync reset clears valid bits, loads defaults
// depends on sbcc_pkg, sbcc_ctrl, sbcc_datapath, sbcc_div
`default_nettype none

module segment_box_collision_check_top
  import sbcc_pkg::*;
#(
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  // command side
  input  wire logic                         start,
  output logic                              busy,
  input  wire logic [CMD_W-1:0]             cmd,
  input  wire logic [SLOT_W-1:0]            slot,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] a_z,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  input  wire logic signed [COORD_BITS-1:0] b_z,
  // result side
  output logic                              done,
  output logic                              reachable,
  output logic [OUT_LEN_W-1:0]              path_length,
  // register writes
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data
);

  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1;

  // command and status between sequencer and datapath
  sbcc_ctl_t        ctl;
  sbcc_sts_t        sts;
  logic [IDX_W-1:0] obs_idx;

  // sequencer: squares, root, step count, increments, then box scan
  sbcc_ctrl #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .cmd     (cmd),
    .sts     (sts),
    .busy    (busy),
    .done    (done),
    .ctl     (ctl),
    .obs_idx (obs_idx)
  );

  // datapath holds the box table, the shared multiplier and divider
  sbcc_datapath #(
    .MAX_OBSTACLES (MAX_OBSTACLES)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_we),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .slot        (slot),
    .a_x         (a_x),
    .a_y         (a_y),
    .a_z         (a_z),
    .b_x         (b_x),
    .b_y         (b_y),
    .b_z         (b_z),
    .ctl         (ctl),
    .obs_idx     (obs_idx),
    .sts         (sts),
    .reachable   (reachable),
    .path_length (path_length)
  );

endmodule

`default_nettype wire

>>> design/sbcc_div.sv
// restoring unsigned divider, one quotient bit per cycle
// depends on sbcc_pkg for operand widths
`default_nettype none

module sbcc_div
  import sbcc_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [DVD_W-1:0] dvd,
  input  wire logic [DVS_W-1:0] dvs,
  output logic                  done,
  output logic [DVD_W-1:0]      quo,
  output logic                  rem_nz
);

  localparam int CNT_W = $clog2(DVD_W);

  logic [DVS_W-1:0] rem;
  logic [DVS_W-1:0] divisor;
  logic [CNT_W-1:0] cnt;
  logic             busy;
  logic [DVS_W:0]   trial;
  logic             take;

  assign trial  = {rem, quo[DVD_W-1]};
  assign take   = trial >= {1'b0, divisor};
  assign rem_nz = rem != '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy    <= 1'b1;
        cnt     <= CNT_W'(DVD_W - 1);
        quo     <= dvd;
        rem     <= '0;
        divisor <= dvs;
      end else if (busy) begin
        if (take) begin
          rem <= DVS_W'(trial - {1'b0, divisor});
        end else begin
          rem <= trial[DVS_W-1:0];
        end
        quo <= {quo[DVD_W-2:0], take};
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sbcc_datapath.sv
// datapath: config registers, obstacle memory, length, walk bounds, point test
// depends on sbcc_pkg and sbcc_div
`default_nettype none

module sbcc_datapath
  import sbcc_pkg::*;
#(
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES,
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
  input  wire logic                         clk,
  input  wire logic                         rst,
  input  wire logic                         cfg_we,
  input  wire logic [CFG_IDX_W-1:0]         cfg_index,
  input  wire logic [CFG_W-1:0]             cfg_data,
  input  wire logic [SLOT_W-1:0]            slot,
  input  wire logic signed [COORD_BITS-1:0] a_x,
  input  wire logic signed [COORD_BITS-1:0] a_y,
  input  wire logic signed [COORD_BITS-1:0] a_z,
  input  wire logic signed [COORD_BITS-1:0] b_x,
  input  wire logic signed [COORD_BITS-1:0] b_y,
  input  wire logic signed [COORD_BITS-1:0] b_z,
  input  wire sbcc_ctl_t                    ctl,
  input  wire logic [IDX_W-1:0]             obs_idx,
  output sbcc_sts_t                         sts,
  output logic                              reachable,
  output logic [OUT_LEN_W-1:0]              path_length
);

  // config
  logic [DIM_W-1:0]  dims_r;
  logic [SIZE_W-1:0] rs_r [MAX_DIMS];
  logic [STEP_W-1:0] step_r;
  logic [DIM_W-1:0]  dims_eff;
  logic [STEP_W-1:0] step_eff;

  always_ff @(posedge clk) begin
    if (rst) begin
      dims_r  <= DIM_W'(2);
      rs_r[0] <= '0;
      rs_r[1] <= '0;
      rs_r[2] <= '0;
      step_r  <= STEP_W'(41);
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DIMS:    dims_r  <= cfg_data[DIM_W-1:0];
        REG_ROBOT_X: rs_r[0] <= cfg_data[SIZE_W-1:0];
        REG_ROBOT_Y: rs_r[1] <= cfg_data[SIZE_W-1:0];
        REG_ROBOT_Z: rs_r[2] <= cfg_data[SIZE_W-1:0];
        REG_STEP:    step_r  <= cfg_data[STEP_W-1:0];
        default:     ;
      endcase
    end
  end

  always_comb begin
    if (dims_r == '0) begin
      dims_eff = DIM_W'(1);
    end else if (32'(dims_r) > MAX_DIMS) begin
      dims_eff = DIM_W'(MAX_DIMS);
    end else begin
      dims_eff = dims_r;
    end
    step_eff = (step_r == '0) ? STEP_W'(1) : step_r;
  end

  // obstacle table
  logic [3*COORD_BITS-1:0] ctr_mem [MAX_OBSTACLES];
  logic [3*SIZE_W-1:0]     siz_mem [MAX_OBSTACLES];
  logic [3*COORD_BITS-1:0] ctr_q;
  logic [3*SIZE_W-1:0]     siz_q;
  logic [MAX_OBSTACLES-1:0] valid_r;
  logic [31:0]             slot_ext;
  logic                    slot_ok;
  logic signed [COORD_BITS-1:0] a_in [MAX_DIMS];
  logic signed [COORD_BITS-1:0] b_in [MAX_DIMS];
  logic [3*COORD_BITS-1:0] ctr_wr;
  logic [3*SIZE_W-1:0]     siz_wr;

  assign a_in[0] = a_x;
  assign a_in[1] = a_y;
  assign a_in[2] = a_z;
  assign b_in[0] = b_x;
  assign b_in[1] = b_y;
  assign b_in[2] = b_z;

  assign slot_ext = 32'(slot);
  assign slot_ok  = slot_ext < 32'(MAX_OBSTACLES);

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      ctr_wr[i*COORD_BITS +: COORD_BITS] = a_in[i];
      // negative sizes clamp to zero
      siz_wr[i*SIZE_W +: SIZE_W] = b_in[i][COORD_BITS-1] ? '0 : b_in[i][SIZE_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && slot_ok) begin
      ctr_mem[slot_ext[IDX_W-1:0]] <= ctr_wr;
      siz_mem[slot_ext[IDX_W-1:0]] <= siz_wr;
    end
    if (ctl.mem_rd) begin
      ctr_q <= ctr_mem[obs_idx];
      siz_q <= siz_mem[obs_idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      valid_r <= '0;
    end else if (ctl.clear) begin
      valid_r <= '0;
    end else if (ctl.load && slot_ok) begin
      valid_r[slot_ext[IDX_W-1:0]] <= 1'b1;
    end
  end

  // segment operands
  logic signed [COORD_BITS-1:0] a_r [MAX_DIMS];
  logic signed [COORD_BITS-1:0] b_r [MAX_DIMS];
  logic [AD_W-1:0]              ad_r [MAX_DIMS];
  logic                         neg_r [MAX_DIMS];
  logic signed [AD_W-1:0]       d_in [MAX_DIMS];

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      d_in[i] = AD_W'(b_in[i]) - AD_W'(a_in[i]);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      for (int i = 0; i < MAX_DIMS; i++) begin
        a_r[i]   <= a_in[i];
        b_r[i]   <= b_in[i];
        ad_r[i]  <= d_in[i][AD_W-1] ? AD_W'(-d_in[i]) : d_in[i];
        neg_r[i] <= d_in[i][AD_W-1];
      end
    end
  end

  // shared multiplier, squares then ad*step
  logic [PROD_W-1:0] prod_r;
  logic [AD_W-1:0]   mul_b;
  logic [SUM_W-1:0]  sum_r;

  assign mul_b = ctl.sq_mul ? ad_r[ctl.dim] : AD_W'(step_eff);

  always_ff @(posedge clk) begin
    if (ctl.sq_mul || ctl.imul) begin
      prod_r <= ad_r[ctl.dim] * mul_b;
    end
    if (ctl.accept) begin
      sum_r <= '0;
    end else if (ctl.sq_acc) begin
      sum_r <= sum_r + SUM_W'(prod_r);
    end
  end

  // integer square root, two radicand bits per step
  logic [SUM_W-1:0] x_r, res_r, bit_r;
  logic [SUM_W-1:0] sq_try;
  logic [LEN_W-1:0] len;

  assign sq_try = res_r + bit_r;
  assign len    = res_r[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (ctl.sqrt_init) begin
      x_r   <= sum_r;
      res_r <= '0;
      bit_r <= SUM_W'(1) << (SUM_W - 2);
    end else if (ctl.sqrt_step) begin
      if (x_r >= sq_try) begin
        x_r   <= x_r - sq_try;
        res_r <= (res_r >> 1) + bit_r;
      end else begin
        res_r <= res_r >> 1;
      end
      bit_r <= bit_r >> 2;
    end
  end

  // divider operand select
  logic [DVD_W-1:0] dvd;
  logic [DVS_W-1:0] dvs;
  logic             div_start;
  logic             div_done;
  logic [DVD_W-1:0] div_q;
  logic             div_rnz;
  logic signed [BND_W-1:0] lb_s, ub_s;
  logic [BND_W-1:0]        lb_abs, ub_abs;
  logic [MAG_W-1:0]        mag_r [MAX_DIMS];

  assign lb_abs    = lb_s[BND_W-1] ? BND_W'(-lb_s) : BND_W'(lb_s);
  assign ub_abs    = ub_s[BND_W-1] ? BND_W'(-ub_s) : BND_W'(ub_s);
  assign div_start = ctl.ndiv_start | ctl.idiv_start | ctl.lo_start | ctl.hi_start;

  always_comb begin
    if (ctl.ndiv_start) begin
      dvd = DVD_W'(len);
      dvs = DVS_W'(step_eff);
    end else if (ctl.idiv_start) begin
      dvd = {prod_r[AD_W+STEP_W-1:0], EXTRA_FRAC'(0)};
      dvs = DVS_W'(len);
    end else if (ctl.lo_start) begin
      dvd = DVD_W'(lb_abs);
      dvs = {mag_r[ctl.dim], 1'b0};
    end else begin
      dvd = DVD_W'(ub_abs);
      dvs = {mag_r[ctl.dim], 1'b0};
    end
  end

  sbcc_div u_div (
    .clk    (clk),
    .rst    (rst),
    .start  (div_start),
    .dvd    (dvd),
    .dvs    (dvs),
    .done   (div_done),
    .quo    (div_q),
    .rem_nz (div_rnz)
  );

  logic [LEN_W-1:0] n_r;

  always_ff @(posedge clk) begin
    if (ctl.accept) begin
      n_r <= '0;
    end else if (ctl.n_store) begin
      n_r <= div_q[LEN_W-1:0];
    end
    if (ctl.mag_store) begin
      mag_r[ctl.dim] <= div_q[MAG_W-1:0];
    end
  end

  // walk bounds for the selected dimension
  logic signed [COORD_BITS-1:0] c_q [MAX_DIMS];
  logic [SIZE_W-1:0]            z_q [MAX_DIMS];
  logic [SIZE_W:0]              rsz;
  logic signed [BND_W-1:0]      c2, st2, s_b, lb, ub;

  always_comb begin
    for (int i = 0; i < MAX_DIMS; i++) begin
      c_q[i] = ctr_q[i*COORD_BITS +: COORD_BITS];
      z_q[i] = siz_q[i*SIZE_W +: SIZE_W];
    end
  end

  always_comb begin
    rsz = (SIZE_W+1)'(rs_r[ctl.dim]) + (SIZE_W+1)'(z_q[ctl.dim]);
    c2  = {{(BND_W-COORD_BITS-EXTRA_FRAC-1){c_q[ctl.dim][COORD_BITS-1]}},
           c_q[ctl.dim], (EXTRA_FRAC+1)'(0)};
    st2 = {{(BND_W-COORD_BITS-EXTRA_FRAC-1){a_r[ctl.dim][COORD_BITS-1]}},
           a_r[ctl.dim], (EXTRA_FRAC+1)'(0)};
    s_b = {(BND_W-SIZE_W-1-EXTRA_FRAC)'(0), rsz, EXTRA_FRAC'(0)};
    lb  = c2 - s_b - st2;
    ub  = c2 + s_b - st2;
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_prep) begin
      // mirror the interval when the walk runs backwards
      lb_s <= neg_r[ctl.dim] ? -ub : lb;
      ub_s <= neg_r[ctl.dim] ? -lb : ub;
    end
  end

  // clipping of the index range [lo, hi]
  logic signed [K_W-1:0] q_k, klo, khi, lo_r, hi_r;

  always_comb begin
    q_k = K_W'(div_q[K_W-2:0]);
    klo = lb_s[BND_W-1] ? -q_k : q_k + K_W'(div_rnz);
    khi = ub_s[BND_W-1] ? -(q_k + K_W'(div_rnz)) : q_k;
  end

  always_ff @(posedge clk) begin
    if (ctl.walk_init) begin
      lo_r <= '0;
      hi_r <= K_W'(n_r) - K_W'(1);
    end else begin
      if (ctl.lo_store && klo > lo_r) lo_r <= klo;
      if (ctl.hi_store && khi < hi_r) hi_r <= khi;
    end
  end

  // end point against the loaded box
  logic                   pt_hit;
  logic signed [AD_W-1:0] pd;
  logic [AD_W:0]          pd2;
  logic [SIZE_W:0]        plim;

  always_comb begin
    pt_hit = 1'b1;
    for (int i = 0; i < MAX_DIMS; i++) begin
      pd   = AD_W'(c_q[i]) - AD_W'(b_r[i]);
      pd2  = {(pd[AD_W-1] ? AD_W'(-pd) : AD_W'(pd)), 1'b0};
      plim = (SIZE_W+1)'(rs_r[i]) + (SIZE_W+1)'(z_q[i]);
      if (i < 32'(dims_eff) && pd2 > (AD_W+1)'(plim)) pt_hit = 1'b0;
    end
  end

  always_comb begin
    sts.dims      = dims_eff;
    sts.len_zero  = len == '0;
    sts.n_zero    = n_r == '0;
    sts.div_done  = div_done;
    sts.obs_valid = valid_r[obs_idx];
    sts.m_zero    = mag_r[ctl.dim] == '0;
    sts.outside   = (lb > 0) || (ub < 0);
    sts.lo_gt_hi  = lo_r > hi_r;
    sts.point_hit = pt_hit;
  end

  // result
  always_ff @(posedge clk) begin
    if (ctl.finish) begin
      reachable <= !ctl.hit;
      if (ctl.hit) begin
        path_length <= '0;
      end else if (len[LEN_W-1:OUT_LEN_W] != '0) begin
        path_length <= '1;
      end else begin
        path_length <= len[OUT_LEN_W-1:0];
      end
    end
  end

endmodule

`default_nettype wire

>>> design/sbcc_ctrl.sv
// sequencer for clear, load and segment check
// depends on sbcc_pkg for command and status structs
`default_nettype none

module sbcc_ctrl
  import sbcc_pkg::*;
#(
  parameter int MAX_OBSTACLES = DEF_MAX_OBSTACLES,
  localparam int IDX_W = (MAX_OBSTACLES > 1) ? $clog2(MAX_OBSTACLES) : 1
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [CMD_W-1:0] cmd,
  input  wire sbcc_sts_t        sts,
  output logic                  busy,
  output logic                  done,
  output sbcc_ctl_t             ctl,
  output logic [IDX_W-1:0]      obs_idx
);

  localparam int CNT_W = $clog2(SQRT_STEPS);

  typedef enum logic [4:0] {
    IDLE, SQ_MUL, SQ_ACC, SQRT_INIT, SQRT_RUN, N_DIV, N_WAIT,
    I_MUL, I_DIV, I_WAIT, OBS_CHK, OBS_LOAD, W_PREP, W_LO, W_LO_WAIT,
    W_HI, W_HI_WAIT, W_CHK, PT_CHK, FIN
  } state_t;

  state_t           state;
  logic [DIM_W-1:0] dim;
  logic [CNT_W-1:0] cnt;
  logic             hit;
  logic             last_dim;
  logic             last_obs;
  logic             go;

  assign last_dim = dim == sts.dims - DIM_W'(1);
  assign last_obs = obs_idx == IDX_W'(MAX_OBSTACLES - 1);
  assign go       = start && !busy;

  always_comb begin
    ctl     = '0;
    ctl.dim = dim;
    ctl.hit = hit;
    unique case (state)
      IDLE: begin
        if (go) begin
          case (cmd)
            CMD_CLEAR: ctl.clear  = 1'b1;
            CMD_LOAD:  ctl.load   = 1'b1;
            CMD_CHECK: ctl.accept = 1'b1;
            default:   ;
          endcase
        end
      end
      SQ_MUL:    ctl.sq_mul     = 1'b1;
      SQ_ACC:    ctl.sq_acc     = 1'b1;
      SQRT_INIT: ctl.sqrt_init  = 1'b1;
      SQRT_RUN:  ctl.sqrt_step  = 1'b1;
      N_DIV:     ctl.ndiv_start = !sts.len_zero;
      N_WAIT:    ctl.n_store    = sts.div_done;
      I_MUL:     ctl.imul       = 1'b1;
      I_DIV:     ctl.idiv_start = 1'b1;
      I_WAIT:    ctl.mag_store  = sts.div_done;
      OBS_CHK:   ctl.mem_rd     = sts.obs_valid;
      OBS_LOAD:  ctl.walk_init  = 1'b1;
      W_PREP:    ctl.walk_prep  = 1'b1;
      W_LO:      ctl.lo_start   = 1'b1;
      W_LO_WAIT: ctl.lo_store   = sts.div_done;
      W_HI:      ctl.hi_start   = 1'b1;
      W_HI_WAIT: ctl.hi_store   = sts.div_done;
      W_CHK:     ;
      PT_CHK:    ;
      FIN:       ctl.finish     = 1'b1;
      default:   ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= IDLE;
      busy    <= 1'b0;
      done    <= 1'b0;
      dim     <= '0;
      cnt     <= '0;
      hit     <= 1'b0;
      obs_idx <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        IDLE: begin
          if (go && cmd == CMD_CHECK) begin
            state <= SQ_MUL;
            busy  <= 1'b1;
            dim   <= '0;
            hit   <= 1'b0;
          end
        end
        SQ_MUL: state <= SQ_ACC;
        SQ_ACC: begin
          if (last_dim) begin
            state <= SQRT_INIT;
          end else begin
            dim   <= dim + 1'b1;
            state <= SQ_MUL;
          end
        end
        SQRT_INIT: begin
          cnt   <= '0;
          state <= SQRT_RUN;
        end
        SQRT_RUN: begin
          cnt <= cnt + 1'b1;
          if (cnt == CNT_W'(SQRT_STEPS - 1)) state <= N_DIV;
        end
        N_DIV: begin
          obs_idx <= '0;
          state   <= sts.len_zero ? OBS_CHK : N_WAIT;
        end
        N_WAIT: begin
          if (sts.div_done) begin
            dim   <= '0;
            state <= I_MUL;
          end
        end
        I_MUL: state <= I_DIV;
        I_DIV: state <= I_WAIT;
        I_WAIT: begin
          if (sts.div_done) begin
            if (last_dim) begin
              obs_idx <= '0;
              state   <= OBS_CHK;
            end else begin
              dim   <= dim + 1'b1;
              state <= I_MUL;
            end
          end
        end
        OBS_CHK: begin
          if (sts.obs_valid) begin
            state <= OBS_LOAD;
          end else if (last_obs) begin
            state <= FIN;
          end else begin
            obs_idx <= obs_idx + 1'b1;
          end
        end
        OBS_LOAD: begin
          dim   <= '0;
          state <= sts.n_zero ? PT_CHK : W_PREP;
        end
        W_PREP: begin
          if (!sts.m_zero) begin
            state <= W_LO;
          end else if (sts.outside) begin
            state <= PT_CHK;
          end else if (last_dim) begin
            hit   <= 1'b1;
            state <= FIN;
          end else begin
            dim <= dim + 1'b1;
          end
        end
        W_LO: state <= W_LO_WAIT;
        W_LO_WAIT: if (sts.div_done) state <= W_HI;
        W_HI: state <= W_HI_WAIT;
        W_HI_WAIT: if (sts.div_done) state <= W_CHK;
        W_CHK: begin
          if (sts.lo_gt_hi) begin
            state <= PT_CHK;
          end else if (last_dim) begin
            hit   <= 1'b1;
            state <= FIN;
          end else begin
            dim   <= dim + 1'b1;
            state <= W_PREP;
          end
        end
        PT_CHK: begin
          if (sts.point_hit) begin
            hit   <= 1'b1;
            state <= FIN;
          end else if (last_obs) begin
            state <= FIN;
          end else begin
            obs_idx <= obs_idx + 1'b1;
            state   <= OBS_CHK;
          end
        end
        FIN: begin
          done  <= 1'b1;
          busy  <= 1'b0;
          state <= IDLE;
        end
        default: state <= IDLE;
      endcase
    end
  end

endmodule

`default_nettype wire

>>> verif/tb_segment_box_collision_check_top.sv
// testbench for segment_box_collision_check_top: directed and random command words,
// a scoreboard class predicting each check result; depends on sbcc_pkg and the design files
`default_nettype none

module tb_segment_box_collision_check_top
  import sbcc_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  // the one command code the package leaves unnamed; the block ignores it
  localparam logic [CMD_W-1:0] CMD_UNUSED = 2'd3;
  localparam int N_BOXES = DEF_MAX_OBSTACLES;
  localparam longint unsigned LEN_SAT = 64'd33554431;

  // one command word as the block sees it
  typedef struct {
    logic [CMD_W-1:0]             op;
    logic [SLOT_W-1:0]            slot;
    logic signed [COORD_BITS-1:0] a [3];
    logic signed [COORD_BITS-1:0] b [3];
  } seg_word_t;

  // one check verdict
  typedef struct {
    logic                 reach;
    logic [OUT_LEN_W-1:0] len;
  } verdict_t;

  // box table copy, register copy, and the verdicts still owed by the block
  class collision_scoreboard;
    longint         ctr [N_BOXES][3];
    longint         ext [N_BOXES][3];
    bit             vld [N_BOXES];
    int unsigned    dims_reg;
    longint         robot [3];
    longint         step_reg;
    verdict_t       owed [$];
    int             mismatches;

    function new();
      foreach (vld[j]) vld[j] = 0;
      dims_reg = 2;
      robot[0] = 0; robot[1] = 0; robot[2] = 0;
      step_reg = 41;
      mismatches = 0;
    endfunction

    function void write_reg(reg_t idx, logic [CFG_W-1:0] data);
      case (idx)
        REG_DIMS:    dims_reg = data[DIM_W-1:0];
        REG_ROBOT_X: robot[0] = data;
        REG_ROBOT_Y: robot[1] = data;
        REG_ROBOT_Z: robot[2] = data;
        REG_STEP:    step_reg = data;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned x);
      longint unsigned res, bsel;
      res = 0;
      bsel = 64'd1 << 62;
      while (bsel > x) bsel >>= 2;
      while (bsel != 0) begin
        if (x >= res + bsel) begin
          x -= res + bsel;
          res = (res >> 1) + bsel;
        end else begin
          res >>= 1;
        end
        bsel >>= 2;
      end
      return res;
    endfunction

    function longint div_down(longint a, longint m);
      longint q;
      q = a / m;
      if ((a % m) != 0 && a < 0) q--;
      return q;
    endfunction

    // any walked point k in 0..n-1 inside box j, solved per axis as an interval of k
    function bit walk_touches(int j, int dims, longint st [3], longint inc [3], longint n);
      longint lo, hi, lb, ub, m, t;
      lo = 0;
      hi = n - 1;
      for (int i = 0; i < dims; i++) begin
        lb = 2 * ctr[j][i] * 65536 - (robot[i] + ext[j][i]) * 65536 - 2 * st[i] * 65536;
        ub = 2 * ctr[j][i] * 65536 + (robot[i] + ext[j][i]) * 65536 - 2 * st[i] * 65536;
        m = 2 * inc[i];
        if (m == 0) begin
          if (lb > 0 || ub < 0) return 0;
          continue;
        end
        if (m < 0) begin
          t = lb;
          m = -m;
          lb = -ub;
          ub = -t;
        end
        if (-div_down(-lb, m) > lo) lo = -div_down(-lb, m);
        if (div_down(ub, m) < hi) hi = div_down(ub, m);
        if (lo > hi) return 0;
      end
      return lo <= hi;
    endfunction

    function bit point_touches(int j, int dims, longint p [3]);
      longint diff;
      for (int i = 0; i < dims; i++) begin
        diff = ctr[j][i] - p[i];
        if (diff < 0) diff = -diff;
        if (2 * diff > robot[i] + ext[j][i]) return 0;
      end
      return 1;
    endfunction

    // apply an accepted word; a check queues its verdict
    function void note_word(seg_word_t w);
      longint st [3], en [3], inc [3], d, n;
      longint unsigned ad [3], sum, len, stp, prod, mag;
      int dims;
      bit hit;
      verdict_t v;
      for (int i = 0; i < 3; i++) begin
        st[i] = w.a[i];
        en[i] = w.b[i];
        inc[i] = 0;
        ad[i] = 0;
      end
      case (w.op)
        CMD_CLEAR: foreach (vld[j]) vld[j] = 0;
        CMD_LOAD: begin
          for (int i = 0; i < 3; i++) begin
            ctr[w.slot][i] = st[i];
            ext[w.slot][i] = en[i] < 0 ? 0 : en[i];
          end
          vld[w.slot] = 1;
        end
        CMD_CHECK: begin
          dims = dims_reg == 0 ? 1 : (dims_reg > MAX_DIMS ? MAX_DIMS : dims_reg);
          stp = step_reg == 0 ? 1 : step_reg;
          sum = 0;
          for (int i = 0; i < dims; i++) begin
            d = en[i] - st[i];
            ad[i] = d < 0 ? -d : d;
            sum += ad[i] * ad[i];
          end
          len = int_sqrt(sum);
          n = 0;
          if (len > 0) begin
            n = len / stp;
            for (int i = 0; i < dims; i++) begin
              prod = ad[i] * stp;
              mag = ((prod / len) << EXTRA_FRAC) + (((prod % len) << EXTRA_FRAC) / len);
              inc[i] = en[i] < st[i] ? -longint'(mag) : longint'(mag);
            end
          end
          hit = 0;
          for (int j = 0; j < N_BOXES && !hit; j++) begin
            if (!vld[j]) continue;
            if (n > 0 && walk_touches(j, dims, st, inc, n)) hit = 1;
            else if (point_touches(j, dims, en)) hit = 1;
          end
          v.reach = !hit;
          v.len = hit ? '0 : (len > LEN_SAT ? LEN_SAT[OUT_LEN_W-1:0] : len[OUT_LEN_W-1:0]);
          owed.push_back(v);
        end
        default: ;
      endcase
    endfunction

    function void check_verdict(logic reach, logic [OUT_LEN_W-1:0] len);
      verdict_t v;
      if (owed.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected result: reachable=%0b path_length=%0d", reach, len);
        return;
      end
      v = owed.pop_front();
      if (reach !== v.reach || len !== v.len) begin
        mismatches++;
        if (mismatches <= 10)
          $display("mismatch: expected reachable=%0b path_length=%0d, got %0b %0d",
                   v.reach, v.len, reach, len);
      end
    endfunction
  endclass

  logic                         clk, rst;
  logic                         start, busy;
  logic [CMD_W-1:0]             cmd;
  logic [SLOT_W-1:0]            slot;
  logic signed [COORD_BITS-1:0] a_x, a_y, a_z, b_x, b_y, b_z;
  logic                         done, reachable;
  logic [OUT_LEN_W-1:0]         path_length;
  logic                         cfg_we;
  logic [CFG_IDX_W-1:0]         cfg_index;
  logic [CFG_W-1:0]             cfg_data;

  collision_scoreboard sb;
  int words_sent;
  int idle_pct;

  segment_box_collision_check_top u_dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .cmd(cmd), .slot(slot),
    .a_x(a_x), .a_y(a_y), .a_z(a_z), .b_x(b_x), .b_y(b_y), .b_z(b_z),
    .done(done), .reachable(reachable), .path_length(path_length),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 0;
    forever #5 clk = ~clk;
  end

  // results last one cycle and cannot be held off, so sample every edge
  always @(posedge clk) begin
    if (!rst && done) sb.check_verdict(reachable, path_length);
  end

  // present a word, hold it until the block takes it, then maybe idle a while
  task automatic send_word(seg_word_t w);
    start <= 1'b1;
    cmd <= w.op;
    slot <= w.slot;
    a_x <= w.a[0]; a_y <= w.a[1]; a_z <= w.a[2];
    b_x <= w.b[0]; b_y <= w.b[1]; b_z <= w.b[2];
    do @(posedge clk); while (busy);
    sb.note_word(w);
    words_sent++;
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk);
    end
  endtask

  // drain all owed verdicts so registers can change safely
  task automatic settle();
    start <= 1'b0;
    @(posedge clk);
    while (sb.owed.size() != 0 || busy) @(posedge clk);
    repeat (5) @(posedge clk);
  endtask

  task automatic write_reg(reg_t idx, int unsigned val);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val[CFG_W-1:0];
    @(posedge clk);
    sb.write_reg(idx, val[CFG_W-1:0]);
    cfg_we <= 1'b0;
  endtask

  task automatic set_regs(int unsigned dm, int unsigned rx, int unsigned ry,
                          int unsigned rz, int unsigned stp);
    write_reg(REG_DIMS, dm);
    write_reg(REG_ROBOT_X, rx);
    write_reg(REG_ROBOT_Y, ry);
    write_reg(REG_ROBOT_Z, rz);
    write_reg(REG_STEP, stp);
    @(posedge clk);
  endtask

  function automatic seg_word_t make_word(logic [CMD_W-1:0] op, int s,
                                          int ax, int ay, int az, int bx, int by, int bz);
    seg_word_t w;
    w.op = op;
    w.slot = s;
    w.a[0] = ax; w.a[1] = ay; w.a[2] = az;
    w.b[0] = bx; w.b[1] = by; w.b[2] = bz;
    return w;
  endfunction

  // coordinate within +-span around zero
  function automatic int near(int span);
    return int'($urandom_range(0, 2 * span)) - span;
  endfunction

  // fully random word, any command including the unused one
  function automatic seg_word_t noise_word();
    seg_word_t w;
    w.op = $urandom_range(0, 3);
    w.slot = $urandom;
    for (int i = 0; i < 3; i++) begin
      w.a[i] = $urandom;
      w.b[i] = $urandom;
    end
    return w;
  endfunction

  // one scene: clear, a few boxes, then segments threading among them
  task automatic run_scene();
    int nbox, nchk, span;
    span = ($urandom_range(3) == 0) ? 1 << 20 : 1 << 16;
    send_word(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    nbox = ($urandom_range(9) == 0) ? $urandom_range(5, 10) : $urandom_range(0, 4);
    for (int k = 0; k < nbox; k++)
      send_word(make_word(CMD_LOAD, $urandom_range(0, 63),
                          near(span), near(span), near(span),
                          near(span / 4), near(span / 4), near(span / 4)));
    nchk = $urandom_range(2, 6);
    for (int k = 0; k < nchk; k++) begin
      if ($urandom_range(9) == 0)
        send_word(noise_word());
      else
        send_word(make_word(CMD_CHECK, $urandom,
                            near(span), near(span), near(span),
                            near(span), near(span), near(span)));
    end
  endtask

  initial begin
    #300ms;
    $display("segment_box_collision_check_top test failed");
    $finish;
  end

  initial begin
    int target;
    sb = new();
    words_sent = 0;
    idle_pct = 14;
    rst = 1'b1;
    start = 1'b0;
    cmd = CMD_CLEAR;
    slot = '0;
    a_x = '0; a_y = '0; a_z = '0; b_x = '0; b_y = '0; b_z = '0;
    cfg_we = 1'b0;
    cfg_index = REG_DIMS;
    cfg_data = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: empty table, extremes, clamped sizes, unused command, zero length
    send_word(make_word(CMD_CHECK, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_CHECK, 0, -8388608, -8388608, -8388608,
                        8388607, 8388607, 8388607));
    send_word(make_word(CMD_LOAD, 0, 4096, 4096, 0, 2048, 2048, 2048));
    send_word(make_word(CMD_LOAD, 63, 8388607, -8388608, 8388607, -1, -8388608, 8388607));
    send_word(make_word(CMD_CHECK, 5, 0, 0, 0, 8192, 8192, 0));
    send_word(make_word(CMD_CHECK, 0, 4096, 4096, 0, 4096, 4096, 0));
    send_word(make_word(CMD_CHECK, 0, 8192, 0, 0, 0, 8192, 0));
    send_word(make_word(CMD_CHECK, 0, 8388607, -8388608, 0, 8388607, -8388608, 0));
    send_word(make_word(CMD_CHECK, 0, -8388608, 8388607, 0, 8388607, -8388608, 0));
    send_word(make_word(CMD_UNUSED, 1, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_LOAD, 7, -100000, 0, 0, 8388607, 10, 10));
    send_word(make_word(CMD_CHECK, 0, -8388608, 5, 0, 8388607, 5, 0));
    send_word(make_word(CMD_CLEAR, 0, 0, 0, 0, 0, 0, 0));
    send_word(make_word(CMD_CHECK, 0, 4096, 4096, 0, 4096, 4096, 0));
    settle();

    // dimension count zero and step zero, then every register at its top
    set_regs(0, 0, 0, 0, 0);
    send_word(make_word(CMD_LOAD, 3, 40960, 0, 0, 4096, 0, 0));
    send_word(make_word(CMD_CHECK, 0, 0, 999, 7, 81920, -999, 3));
    send_word(make_word(CMD_CHECK, 0, 0, 0, 0, 20000, 0, 0));
    settle();
    set_regs(3, 8388607, 8388607, 8388607, 8388607);
    send_word(make_word(CMD_CHECK, 0, -8388608, -8388608, -8388608, 8388607, 8388607, 8388607));
    send_word(make_word(CMD_CHECK, 0, 8388607, 8388607, 8388607, 8388607, 8388607, 8388607));
    settle();

    // random phases, each with its own register setting and sender idling
    target = 1300;
    for (int ph = 0; words_sent < target; ph++) begin
      idle_pct = ph < 3 ? 14 : (ph < 6 ? 47 : 0);
      case (ph % 6)
        0: set_regs(2, 0, 0, 0, 41);
        1: set_regs(3, 4096, 2048, 1024, 41);
        2: set_regs(1, 8192, 0, 0, 1);
        3: set_regs($urandom_range(0, 3), $urandom_range(0, 1 << 15),
                    $urandom_range(0, 1 << 15), $urandom_range(0, 1 << 15),
                    $urandom_range(1, 1 << 14));
        4: set_regs(3, 0, 0, 0, 8388607);
        default: set_regs(2, $urandom, $urandom, $urandom, $urandom);
      endcase
      for (int s = 0; s < 25 && words_sent < target; s++) run_scene();
      settle();
    end

    settle();
    repeat (50) @(posedge clk);
    if (sb.mismatches == 0 && sb.owed.size() == 0)
      $display("segment_box_collision_check_top test passed");
    else
      $display("segment_box_collision_check_top test failed");
    $finish;
  end

endmodule

`default_nettype wire
